/* src/lru_recency_tracker_unit_defines.svh */
// Assertion macros shared by the recency tracker modules.
`ifndef LRU_RECENCY_TRACKER_UNIT_DEFINES_SVH
`define LRU_RECENCY_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define LRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lru tracker check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define LRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lru tracker check failed");

`endif

/* src/lrt_pkg.sv */
// Shared constants, codes and control types of the recency tracker.
package lrt_pkg;

    localparam int TRACK_DEPTH = 32;
    localparam int KEY_BITS    = 16;
    localparam int IDX_W       = $clog2(TRACK_DEPTH);
    localparam int CNT_W       = $clog2(TRACK_DEPTH + 1);
    localparam int CMP_W       = CNT_W + 1;
    localparam int ACT_W       = 3;
    localparam int KEYID_W     = 16;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = 6;
    localparam int CAP_W       = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    localparam logic [ACT_W-1:0] ACT_TRACK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EVICT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop;
    } lrt_cmd_t;

    typedef struct packed {
        logic is_evict;
        logic evict_more;
        logic last_pop;
        logic out_free;
    } lrt_status_t;

endpackage

/* src/lru_recency_tracker_unit.sv */
// LRU recency tracker: up to 32 distinct 16-bit keys held in recency order.
// Track, touch, remove and query each register the beat, then do the
// parallel key match across all cells and the shift of the order once the
// output register is free. Evict excess gives one result beat per cycle
// while the output is not stalled, one for each removed key, least recent
// first. A new input beat is taken as soon as the previous item's
// last result is in the output register, while that result still waits.
// The capacity register (reset 32, zero acts as one) may be written only
// while the block is idle; cfg_ready is always high.
module lru_recency_tracker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lrt_pkg::ACT_W-1:0]     s_action,
    input  logic [lrt_pkg::KEYID_W-1:0]   s_key_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lrt_pkg::STAT_W-1:0]    m_status,
    output logic                          m_is_tracked,
    output logic [lrt_pkg::OCC_W-1:0]     m_occupancy,
    output logic [lrt_pkg::KEYID_W-1:0]   m_evicted_key,
    output logic                          m_evicted_valid,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrt_pkg::CAP_W-1:0]     cfg_capacity
);
    import lrt_pkg::*;

    lrt_cmd_t    cmd;
    lrt_status_t stat;

    assign cfg_ready = 1'b1;

    lrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lrt_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_action        (s_action),
        .s_key_id        (s_key_id),
        .cfg_valid       (cfg_valid),
        .cfg_capacity    (cfg_capacity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_is_tracked    (m_is_tracked),
        .m_occupancy     (m_occupancy),
        .m_evicted_key   (m_evicted_key),
        .m_evicted_valid (m_evicted_valid),
        .m_last          (m_last)
    );

endmodule

/* src/lrt_ctrl.sv */
// Controller state machine of the recency tracker.
`include "lru_recency_tracker_unit_defines.svh"

module lrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lrt_pkg::lrt_status_t stat,
    output lrt_pkg::lrt_cmd_t    cmd
);
    import lrt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVICT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.pop     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec = 1'b1;
                    if (stat.is_evict && stat.evict_more && !stat.last_pop) begin
                        state_next = ST_EVICT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EVICT: begin
                if (stat.out_free) begin
                    cmd.pop = 1'b1;
                    if (stat.last_pop) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    `LRT_ASSERT_NOW(a_ready_idle, s_ready_reg, state_reg == ST_IDLE)
    `LRT_ASSERT_NEXT(a_capture_exec, cmd.capture, state_reg == ST_EXEC)
    `LRT_ASSERT_NOW(a_evict_state, state_reg == ST_EVICT, stat.evict_more)

endmodule

/* src/lrt_datapath.sv */
// Datapath: key cells, count, capacity register and result register.
`include "lru_recency_tracker_unit_defines.svh"

module lrt_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrt_pkg::lrt_cmd_t            cmd,
    output lrt_pkg::lrt_status_t         stat,
    input  logic [lrt_pkg::ACT_W-1:0]    s_action,
    input  logic [lrt_pkg::KEYID_W-1:0]  s_key_id,
    input  logic                         cfg_valid,
    input  logic [lrt_pkg::CAP_W-1:0]    cfg_capacity,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lrt_pkg::STAT_W-1:0]   m_status,
    output logic                         m_is_tracked,
    output logic [lrt_pkg::OCC_W-1:0]    m_occupancy,
    output logic [lrt_pkg::KEYID_W-1:0]  m_evicted_key,
    output logic                         m_evicted_valid,
    output logic                         m_last
);
    import lrt_pkg::*;

    logic [KEY_BITS-1:0] keys_reg [TRACK_DEPTH];
    logic [KEY_BITS-1:0] keys_next [TRACK_DEPTH];
    logic [KEY_BITS-1:0] up_keys [TRACK_DEPTH];
    logic [CNT_W-1:0]    cnt_reg, cnt_next, cnt_dec;
    logic [CAP_W-1:0]    cap_reg, cap_eff;
    logic [ACT_W-1:0]    act_reg;
    logic [KEY_BITS-1:0] key_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                tracked_reg, tracked_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [KEYID_W-1:0]  ekey_reg, ekey_next;
    logic                evalid_reg, evalid_next;
    logic                last_reg, last_next;

    logic [TRACK_DEPTH-1:0] match;
    logic                   hit;
    logic [IDX_W-1:0]       pos;
    logic                   do_pop;
    logic                   load;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_is_tracked    = tracked_reg;
    assign m_occupancy     = occ_reg;
    assign m_evicted_key   = ekey_reg;
    assign m_evicted_valid = evalid_reg;
    assign m_last          = last_reg;

    for (genvar g = 0; g < TRACK_DEPTH; g++) begin : g_up
        if (g < TRACK_DEPTH - 1) begin : g_mid
            assign up_keys[g] = keys_reg[g+1];
        end else begin : g_end
            assign up_keys[g] = '0;
        end
    end

    always_comb begin
        match = '0;
        pos   = '0;
        for (int i = 0; i < TRACK_DEPTH; i++) begin
            match[i] = (CNT_W'(i) < cnt_reg) && (keys_reg[i] == key_reg);
            pos      = pos | (match[i] ? IDX_W'(i) : '0);
        end
        hit = |match;
    end

    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign cap_eff = (cap_reg == '0) ? CAP_W'(1) : cap_reg;

    assign stat.is_evict   = (act_reg == ACT_EVICT);
    assign stat.evict_more = CMP_W'(cnt_reg) > CMP_W'(cap_eff);
    assign stat.last_pop   = CMP_W'(cnt_reg) <= (CMP_W'(cap_eff) + CMP_W'(1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign do_pop = cmd.pop || (cmd.exec && stat.is_evict && stat.evict_more);
    assign load   = cmd.exec || cmd.pop;

    always_comb begin
        keys_next    = keys_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        tracked_next = tracked_reg;
        occ_next     = occ_reg;
        ekey_next    = ekey_reg;
        evalid_next  = evalid_reg;
        last_next    = last_reg;
        if (load) begin
            m_valid_next = 1'b1;
            status_next  = ST_DONE;
            tracked_next = 1'b0;
            ekey_next    = '0;
            evalid_next  = 1'b0;
            last_next    = 1'b1;
        end
        if (do_pop) begin
            keys_next   = up_keys;
            cnt_next    = cnt_dec;
            ekey_next   = KEYID_W'(keys_reg[0]);
            evalid_next = 1'b1;
            last_next   = stat.last_pop;
        end else if (cmd.exec) begin
            case (act_reg)
                ACT_TRACK: begin
                    if (hit) begin
                        status_next = ST_IGNORED;
                    end else if (cnt_reg == CNT_W'(TRACK_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        keys_next[cnt_reg[IDX_W-1:0]] = key_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ACT_TOUCH: begin
                    if (hit) begin
                        for (int i = 0; i < TRACK_DEPTH; i++) begin
                            if (IDX_W'(i) >= pos) begin
                                keys_next[i] = up_keys[i];
                            end
                        end
                        keys_next[cnt_dec[IDX_W-1:0]] = key_reg;
                    end else begin
                        status_next = ST_IGNORED;
                    end
                end
                ACT_REMOVE: begin
                    if (hit) begin
                        for (int i = 0; i < TRACK_DEPTH; i++) begin
                            if (IDX_W'(i) >= pos) begin
                                keys_next[i] = up_keys[i];
                            end
                        end
                        cnt_next = cnt_dec;
                    end else begin
                        status_next = ST_IGNORED;
                    end
                end
                ACT_EVICT: begin
                    status_next = ST_DONE;
                end
                ACT_QUERY: begin
                    tracked_next = hit;
                end
                default: begin
                    status_next = ST_IGNORED;
                end
            endcase
        end
        if (load) begin
            occ_next = OCC_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                cap_reg <= cfg_capacity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        keys_reg    <= keys_next;
        status_reg  <= status_next;
        tracked_reg <= tracked_next;
        occ_reg     <= occ_next;
        ekey_reg    <= ekey_next;
        evalid_reg  <= evalid_next;
        last_reg    <= last_next;
        if (cmd.capture) begin
            act_reg <= s_action;
            key_reg <= s_key_id[KEY_BITS-1:0];
        end
    end

    `LRT_ASSERT_NOW(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(TRACK_DEPTH))
    `LRT_ASSERT_NOW(a_load_free, load, stat.out_free)
    `LRT_ASSERT_NOW(a_pop_nonempty, do_pop, cnt_reg != '0)
    `LRT_ASSERT_NEXT(a_load_valid, load, m_valid_reg)

endmodule

/* tb/sv/tb_lru_recency_tracker_unit.sv */
// Self-checking testbench for the LRU recency tracker: directed table, then random phases.
`timescale 1ns / 1ps

module tb_lru_recency_tracker_unit;
    import lrt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_GAP   = 4;
    localparam int DRAIN_TAIL   = 20;
    localparam int POOL_SIZE    = 36;
    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES   = 6;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               is_tracked;
        logic [OCC_W-1:0]   occupancy;
        logic [KEYID_W-1:0] evicted_key;
        logic               evicted_valid;
        logic               last;
    } lru_result_t;

    typedef struct {
        logic [ACT_W-1:0]   action;
        logic [KEYID_W-1:0] key;
        bit                 typed;
        lru_result_t        res;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ACT_W-1:0]    s_action;
    logic [KEYID_W-1:0]  s_key_id;
    logic                m_valid;
    logic                m_ready;
    logic [STAT_W-1:0]   m_status;
    logic                m_is_tracked;
    logic [OCC_W-1:0]    m_occupancy;
    logic [KEYID_W-1:0]  m_evicted_key;
    logic                m_evicted_valid;
    logic                m_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_capacity;

    logic [KEYID_W-1:0]  lru_keys [TRACK_DEPTH];
    int                  lru_count;
    logic [CAP_W-1:0]    lru_capacity;
    lru_result_t         pending_results [$];
    logic [KEYID_W-1:0]  key_pool [POOL_SIZE];

    idle_mode_t          idle_mode;
    bit                  hold_req;
    int                  hold_left;
    int                  mismatches;
    int                  stall_cycles;

    int                  phase_cap   [NUM_PHASES] = '{32, 63, 1, 0, 16, 33};
    idle_mode_t          phase_mode  [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                      IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
    int                  phase_items [NUM_PHASES] = '{60, 40, 40, 40, 40, 30};
    int                  phase_track [NUM_PHASES] = '{75, 75, 35, 35, 35, 35};

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{ACT_QUERY,  16'h0000, 1'b1, '{ST_DONE,    1'b0, 6'd0, 16'h0000, 1'b0, 1'b1}},
        '{ACT_EVICT,  16'h0000, 1'b1, '{ST_DONE,    1'b0, 6'd0, 16'h0000, 1'b0, 1'b1}},
        '{ACT_TOUCH,  16'hFFFF, 1'b1, '{ST_IGNORED, 1'b0, 6'd0, 16'h0000, 1'b0, 1'b1}},
        '{ACT_REMOVE, 16'h0000, 1'b1, '{ST_IGNORED, 1'b0, 6'd0, 16'h0000, 1'b0, 1'b1}},
        '{ACT_RSVD5,  16'h1234, 1'b1, '{ST_IGNORED, 1'b0, 6'd0, 16'h0000, 1'b0, 1'b1}},
        '{ACT_TRACK,  16'h0000, 1'b1, '{ST_DONE,    1'b0, 6'd1, 16'h0000, 1'b0, 1'b1}},
        '{ACT_TRACK,  16'hFFFF, 1'b1, '{ST_DONE,    1'b0, 6'd2, 16'h0000, 1'b0, 1'b1}},
        '{ACT_TRACK,  16'h0000, 1'b1, '{ST_IGNORED, 1'b0, 6'd2, 16'h0000, 1'b0, 1'b1}},
        '{ACT_QUERY,  16'hFFFF, 1'b1, '{ST_DONE,    1'b1, 6'd2, 16'h0000, 1'b0, 1'b1}},
        '{ACT_RSVD6,  16'hFFFF, 1'b1, '{ST_IGNORED, 1'b0, 6'd2, 16'h0000, 1'b0, 1'b1}},
        '{ACT_RSVD7,  16'h0000, 1'b1, '{ST_IGNORED, 1'b0, 6'd2, 16'h0000, 1'b0, 1'b1}},
        '{ACT_TRACK,  16'h5555, 1'b0, '0},
        '{ACT_TRACK,  16'hAAAA, 1'b0, '0},
        '{ACT_TOUCH,  16'h0000, 1'b0, '0},
        '{ACT_QUERY,  16'h0000, 1'b0, '0},
        '{ACT_REMOVE, 16'hFFFF, 1'b0, '0},
        '{ACT_QUERY,  16'hFFFF, 1'b0, '0},
        '{ACT_TRACK,  16'h8001, 1'b0, '0},
        '{ACT_TOUCH,  16'h5555, 1'b0, '0},
        '{ACT_EVICT,  16'hFFFF, 1'b0, '0},
        '{ACT_QUERY,  16'hAAAA, 1'b0, '0}
    };

    lru_recency_tracker_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key_id        (s_key_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_is_tracked    (m_is_tracked),
        .m_occupancy     (m_occupancy),
        .m_evicted_key   (m_evicted_key),
        .m_evicted_valid (m_evicted_valid),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_capacity    (cfg_capacity)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int find_slot(logic [KEYID_W-1:0] key);
        for (int i = 0; i < lru_count; i++) begin
            if (lru_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < lru_count; i++) begin
            lru_keys[i] = lru_keys[i + 1];
        end
        lru_count--;
    endfunction

    function automatic void queue_result(logic [STAT_W-1:0] status, logic tracked,
                                         logic [KEYID_W-1:0] ekey, logic evalid, logic last);
        lru_result_t r;
        r.status        = status;
        r.is_tracked    = tracked;
        r.occupancy     = OCC_W'(lru_count);
        r.evicted_key   = ekey;
        r.evicted_valid = evalid;
        r.last          = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void apply_lru_action(logic [ACT_W-1:0] act, logic [KEYID_W-1:0] key);
        int                 pos;
        int                 cap;
        int                 n;
        logic [KEYID_W-1:0] gone;
        pos = find_slot(key);
        case (act)
            ACT_TRACK: begin
                if (pos >= 0) begin
                    queue_result(ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
                end else if (lru_count >= TRACK_DEPTH) begin
                    queue_result(ST_FULL, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    lru_keys[lru_count] = key;
                    lru_count++;
                    queue_result(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ACT_TOUCH: begin
                if (pos < 0) begin
                    queue_result(ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    drop_slot(pos);
                    lru_keys[lru_count] = key;
                    lru_count++;
                    queue_result(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (pos < 0) begin
                    queue_result(ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    drop_slot(pos);
                    queue_result(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ACT_EVICT: begin
                cap = (lru_capacity == '0) ? 1 : int'(lru_capacity);
                if (lru_count <= cap) begin
                    queue_result(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    n = lru_count - cap;
                    for (int i = 0; i < n; i++) begin
                        gone = lru_keys[0];
                        drop_slot(0);
                        queue_result(ST_DONE, 1'b0, gone, 1'b1, i + 1 == n);
                    end
                end
            end
            ACT_QUERY: begin
                queue_result(ST_DONE, pos >= 0, '0, 1'b0, 1'b1);
            end
            default: begin
                queue_result(ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 48;
            IDLE_BOTH:   return $urandom_range(99) < 21;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 48;
            IDLE_BOTH:     return $urandom_range(99) < 21;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(int track_pct);
        int r;
        if ($urandom_range(99) < track_pct) begin
            return ACT_TRACK;
        end
        r = $urandom_range(99);
        if (r < 25) begin
            return ACT_TOUCH;
        end else if (r < 45) begin
            return ACT_REMOVE;
        end else if (r < 65) begin
            return ACT_EVICT;
        end else if (r < 95) begin
            return ACT_QUERY;
        end
        return ACT_W'($urandom_range(int'(ACT_RSVD5), int'(ACT_RSVD7)));
    endfunction

    function automatic logic [KEYID_W-1:0] pick_key(logic [ACT_W-1:0] act);
        if (act != ACT_TRACK && lru_count > 0 && $urandom_range(99) < 70) begin
            return lru_keys[$urandom_range(lru_count - 1)];
        end
        if ($urandom_range(99) < 10) begin
            return KEYID_W'($urandom());
        end
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [KEYID_W-1:0] key,
                             input bit typed, input lru_result_t typed_res);
        while (sender_idles()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_key_id <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_lru_action(act, key);
        if (typed) begin
            pending_results[pending_results.size() - 1] = typed_res;
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_GAP) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid    <= 1'b1;
        cfg_capacity <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        lru_capacity = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input lru_result_t want,
                                 input lru_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected st=%0d trk=%0d occ=%0d key=%h ev=%0d last=%0d",
                     what, want.status, want.is_tracked, want.occupancy,
                     want.evicted_key, want.evicted_valid, want.last);
            $display("   actual   st=%0d trk=%0d occ=%0d key=%h ev=%0d last=%0d",
                     got.status, got.is_tracked, got.occupancy,
                     got.evicted_key, got.evicted_valid, got.last);
        end
    endtask

    always @(posedge aclk) begin : result_check
        lru_result_t got;
        lru_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_is_tracked, m_occupancy, m_evicted_key, m_evicted_valid,
                    m_last};
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.is_tracked !== want.is_tracked ||
                    got.occupancy !== want.occupancy || got.evicted_key !== want.evicted_key ||
                    got.evicted_valid !== want.evicted_valid || got.last !== want.last) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !receiver_stalls();
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = '0;
        s_key_id     = '0;
        cfg_valid    = 1'b0;
        cfg_capacity = '0;
        idle_mode    = IDLE_NONE;
        hold_req     = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        lru_count    = 0;
        lru_capacity = CAP_RESET;
        phase_cap[4] = $urandom_range(2, 31);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_beat(directed_rows[i].action, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_capacity(CAP_W'(phase_cap[p]));
            idle_mode = phase_mode[p];
            for (int k = 0; k < POOL_SIZE; k++) begin
                key_pool[k] = KEYID_W'($urandom());
            end
            if (phase_mode[p] == IDLE_NONE) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < phase_items[p]; n++) begin : random_beat
                logic [ACT_W-1:0] act;
                act = pick_action(phase_track[p]);
                send_beat(act, pick_key(act), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
